// ===== hw/rtl/gfla_pkg.sv =====
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types and constants of the grouped free-list block allocator.
// ----------------------------------------------------------------------------
package gfla_pkg;

  localparam int BN_W   = 11;   // block number width
  localparam int RSV_W  = 10;   // reserved block count width
  localparam int BN_MAX = 2047; // largest block number a word can carry

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } gfla_op_e_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } gfla_status_t;

  // request class, decided when the word is accepted
  typedef enum logic [2:0] {
    KIND_ALLOC_EMPTY,
    KIND_ALLOC,
    KIND_BAD_INDEX,
    KIND_FREE_EMPTY,
    KIND_FREE_SELF,
    KIND_FREE
  } gfla_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_COMMIT
  } gfla_state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic commit;
  } gfla_cmd_t;

  typedef struct packed {
    gfla_kind_t kind_in;
    logic       sweep_last;
  } gfla_sts_t;

endpackage

// ===== hw/rtl/gfla_chan_if.sv =====
// ----------------------------------------------------------------------------
// gfla channel interfaces
// Valid/ready channels for requests and results of the block allocator.
// ----------------------------------------------------------------------------
interface gfla_in_if import gfla_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [BN_W-1:0] block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface gfla_out_if import gfla_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BN_W-1:0] block_number;
  gfla_status_t    status;

  modport source (output valid, output block_number, output status, input ready);
  modport sink   (input valid, input block_number, input status, output ready);
endinterface

// ===== hw/rtl/gfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// gfla_ctrl
// Sequencer of the allocator: accept, slot sweep, drain, commit.
// ----------------------------------------------------------------------------
module gfla_ctrl import gfla_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  gfla_sts_t sts,
  output gfla_cmd_t cmd
);

  gfla_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          // nothing to look up in memory for these two
          if (sts.kind_in == KIND_ALLOC_EMPTY || sts.kind_in == KIND_BAD_INDEX) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r != ST_IDLE)
    else $error("accepted word did not start processing");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

// ===== hw/rtl/gfla_datapath.sv =====
// ----------------------------------------------------------------------------
// gfla_datapath
// Node memory, list head, slot sweep and result register of the allocator.
// ----------------------------------------------------------------------------
module gfla_datapath import gfla_pkg::*; #(
  parameter int TOTAL_BLOCKS   = 1024,
  parameter int WORDS_PER_NODE = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gfla_cmd_t        cmd,
  output gfla_sts_t        sts,
  input  logic             in_operation,
  input  logic [BN_W-1:0]  in_block_index,
  input  logic             cfg_wr_en,
  input  logic [RSV_W-1:0] cfg_wr_data,
  output logic [BN_W-1:0]  res_block_number,
  output gfla_status_t     res_status
);

  localparam int NUM_BLK = (TOTAL_BLOCKS < BN_MAX) ? TOTAL_BLOCKS : BN_MAX;
  localparam int DEPTH   = (NUM_BLK + 1) * WORDS_PER_NODE;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(WORDS_PER_NODE);
  localparam logic [SW-1:0] LINK_SLOT = '0;
  localparam logic [SW-1:0] SELF_SLOT = SW'(1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(WORDS_PER_NODE - 1);

  logic [BN_W-1:0]  mem [DEPTH];
  logic [BN_W-1:0]  rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [BN_W-1:0]  wr_data;

  logic [RSV_W-1:0] rsv_r;
  logic [BN_W-1:0]  head_r, head_nxt;
  logic [AW-1:0]    head_base_r;
  gfla_kind_t       kind_r, kind_in;
  logic [BN_W-1:0]  idx_r;
  logic [AW-1:0]    idx_base_r;
  logic [SW-1:0]    cnt_r;
  logic             rd_vld_r;
  logic [SW-1:0]    rd_slot_r;
  logic [BN_W-1:0]  link_r;
  logic             hit_r;
  logic [SW-1:0]    hit_slot_r;
  logic [BN_W-1:0]  hit_val_r;
  logic             slot_match;
  logic             idx_bad;
  logic [BN_W-1:0]  res_bn_r;
  gfla_status_t     res_status_r;

  // request classification
  always_comb begin
    idx_bad = (in_block_index <= BN_W'(rsv_r)) || (32'(in_block_index) > TOTAL_BLOCKS);
    if (in_operation == OP_FREE) begin
      if (idx_bad) begin
        kind_in = KIND_BAD_INDEX;
      end else if (head_r == '0) begin
        kind_in = KIND_FREE_EMPTY;
      end else if (in_block_index == head_r) begin
        kind_in = KIND_FREE_SELF;
      end else begin
        kind_in = KIND_FREE;
      end
    end else if (head_r == '0) begin
      kind_in = KIND_ALLOC_EMPTY;
    end else begin
      kind_in = KIND_ALLOC;
    end
  end

  assign sts.kind_in    = kind_in;
  assign sts.sweep_last = (cnt_r == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_r <= '0;
    end else if (cfg_wr_en) begin
      rsv_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    head_base_r <= AW'(32'(head_r) * WORDS_PER_NODE);
    if (cmd.accept) begin
      kind_r     <= kind_in;
      idx_r      <= in_block_index;
      idx_base_r <= AW'(32'(in_block_index) * WORDS_PER_NODE);
    end
  end

  // sweep counter and delayed read tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.sweep;
      if (cmd.accept) begin
        cnt_r <= '0;
      end else if (cmd.sweep) begin
        cnt_r <= cnt_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= cnt_r;
  end

  // allocate looks for a listed block, free looks for an empty slot
  assign slot_match = (kind_r == KIND_ALLOC) ? (rd_data_r != '0) : (rd_data_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.accept) begin
      hit_r <= 1'b0;
    end else if (rd_vld_r && rd_slot_r != LINK_SLOT && !hit_r && slot_match) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (rd_slot_r == LINK_SLOT) begin
        link_r <= rd_data_r;
      end else if (!hit_r && slot_match) begin
        hit_slot_r <= rd_slot_r;
        hit_val_r  <= rd_data_r;
      end
    end
  end

  // node memory
  assign rd_addr = head_base_r + AW'(cnt_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_base_r + AW'(cnt_r);
    wr_data = '0;
    if (cmd.sweep) begin
      // freed block is blanked; a freed head lists itself in slot 1, after its link slot
      case (kind_r) inside
        KIND_FREE, KIND_FREE_EMPTY, KIND_FREE_SELF: begin
          wr_en = 1'b1;
          if (kind_r == KIND_FREE_SELF && cnt_r == SELF_SLOT) begin
            wr_data = idx_r;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end else if (cmd.commit) begin
      case (kind_r)
        KIND_ALLOC: begin
          wr_en   = 1'b1;
          wr_addr = hit_r ? head_base_r + AW'(hit_slot_r) : head_base_r;
        end
        KIND_FREE: begin
          wr_en = 1'b1;
          if (hit_r) begin
            wr_addr = head_base_r + AW'(hit_slot_r);
            wr_data = idx_r;
          end else begin
            wr_addr = idx_base_r;
            wr_data = head_r;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // list head
  always_comb begin
    head_nxt = head_r;
    if (cmd.commit) begin
      case (kind_r)
        KIND_ALLOC:      if (!hit_r) head_nxt = link_r;
        KIND_FREE:       if (!hit_r) head_nxt = idx_r;
        KIND_FREE_EMPTY: head_nxt = idx_r;
        default:         head_nxt = head_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (kind_r)
        KIND_ALLOC: begin
          res_bn_r     <= hit_r ? hit_val_r : head_r;
          res_status_r <= STAT_OK;
        end
        KIND_ALLOC_EMPTY: begin
          res_bn_r     <= '0;
          res_status_r <= STAT_NO_FREE;
        end
        KIND_BAD_INDEX: begin
          res_bn_r     <= '0;
          res_status_r <= STAT_BAD_INDEX;
        end
        default: begin
          res_bn_r     <= '0;
          res_status_r <= STAT_OK;
        end
      endcase
    end
  end

  assign res_block_number = res_bn_r;
  assign res_status       = res_status_r;

  a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cmd.sweep || cmd.commit))
    else $error("node memory written outside sweep or commit");

  a_empty_free_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_r == KIND_FREE_EMPTY) |=> head_r == $past(idx_r))
    else $error("free on empty list did not set head");

endmodule

// ===== hw/rtl/grouped_free_list_block_allocator.sv =====
// ----------------------------------------------------------------------------
// grouped_free_list_block_allocator
// Block allocator over a grouped free list stored inside the free blocks.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request words, operation (0 allocate, 1 free) and block_index.
//   out_ch : one result word per request, block_number and status
//            (0 ok, 1 no free block, 2 invalid block index).
//   cfg_*  : write of reserved_block_count; write only while idle.
// Each request sweeps the WORDS_PER_NODE words of the head node through the
// node memory, one read per cycle, while the write port blanks the freed
// block in the same sweep, then passes a drain state before its commit;
// allocate on an empty list and an invalid free skip the sweep and go
// straight to commit. One request is in flight at a time and the next
// is accepted the cycle after the previous result is registered.
// The result sits in an output register; while the receiver stalls the
// block accepts one more request and holds it before commit until the
// register frees up.
// Reset empties the list and clears reserved_block_count; the node memory
// is not cleared, since every block is blanked when it is freed.
// ----------------------------------------------------------------------------
module grouped_free_list_block_allocator import gfla_pkg::*; #(
  parameter int TOTAL_BLOCKS   = 1024,
  parameter int WORDS_PER_NODE = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  gfla_in_if.sink          in_ch,
  gfla_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [RSV_W-1:0] cfg_wr_data
);

  gfla_cmd_t cmd;
  gfla_sts_t sts;

  gfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gfla_datapath #(
    .TOTAL_BLOCKS   (TOTAL_BLOCKS),
    .WORDS_PER_NODE (WORDS_PER_NODE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_ch.operation),
    .in_block_index   (in_ch.block_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .res_block_number (out_ch.block_number),
    .res_status       (out_ch.status)
  );

endmodule
